/* hdl/stst_pkg.sv */
// Shared types, codes and float compare helpers for the sorted time sample table.
package stst_pkg;

    localparam int DEPTH_DEF = 64;

    localparam logic [2:0] FN_INSERT = 3'd0;
    localparam logic [2:0] FN_REMOVE = 3'd1;
    localparam logic [2:0] FN_LOCATE = 3'd2;
    localparam logic [2:0] FN_READ   = 3'd3;
    localparam logic [2:0] FN_CLEAR  = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_TIME = 3'd1;
    localparam logic [2:0] ST_BAD_KIND = 3'd2;
    localparam logic [2:0] ST_MISMATCH = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;
    localparam logic [2:0] ST_FULL     = 3'd6;

    localparam logic [3:0] KIND_NONE    = 4'd0;
    localparam logic [3:0] KIND_BLOCKED = 4'd1;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] sample_time;
        logic [3:0]  value_kind;
        logic [63:0] value_payload;
        logic [5:0]  entry_index;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  lo_index;
        logic [5:0]  hi_index;
        logic [63:0] lo_time;
        logic [63:0] hi_time;
        logic        exact_hit;
        logic [63:0] held_value;
        logic        held_blocked;
        logic [3:0]  table_kind;
        logic [6:0]  sample_count;
    } res_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SEL,
        S_RD
    } state_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_INSERT,
        WR_REPLACE,
        WR_REMOVE
    } wr_op_t;

    typedef struct packed {
        logic [63:0] tbits;
        logic [63:0] payload;
        logic        blocked;
    } entry_t;

    typedef struct packed {
        logic        load;
        logic        by_index;
        logic [63:0] query;
    } cmp_ctl_t;

    typedef struct packed {
        wr_op_t op;
        entry_t fresh;
    } wr_ctl_t;

    function automatic logic f_is_nan(input logic [63:0] a);
        return (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    endfunction

    // IEEE-754 a < b, false on any NaN, zeros of either sign equal.
    function automatic logic f_lt(input logic [63:0] a, input logic [63:0] b);
        logic r;
        if (f_is_nan(a) || f_is_nan(b))
            r = 1'b0;
        else if (a[62:0] == 63'd0 && b[62:0] == 63'd0)
            r = 1'b0;
        else if (a[63] && !b[63])
            r = 1'b1;
        else if (!a[63] && b[63])
            r = 1'b0;
        else if (!a[63])
            r = a[62:0] < b[62:0];
        else
            r = a[62:0] > b[62:0];
        return r;
    endfunction

    function automatic logic f_eq(input logic [63:0] a, input logic [63:0] b);
        return !f_is_nan(a) && !f_is_nan(b)
            && ((a == b) || (a[62:0] == 63'd0 && b[62:0] == 63'd0));
    endfunction

endpackage

/* hdl/sorted_time_sample_table.sv */
// Top level of the sorted time sample table: control sequencer, slot chain and result register.
// A command passes through the compare, select and apply states before its result is registered.
// cmd_stall holds while the sequencer is busy, so a new command is taken only after the apply step
// of the previous one; a new command is taken while the previous result still waits on res_stall.
// Reset: rst_n clears the sample count, the established kind, the sequencer and the result
// valid; slot contents are left as they are and only slots below the count are ever read.
module sorted_time_sample_table import stst_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    state_t          state_reg;
    state_t          state_next;
    cmd_t            op_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [3:0]      kind_reg;
    logic [3:0]      kind_next;
    logic [CW-1:0]   pos_reg;
    logic [CW-1:0]   pos_next;
    logic            eq_pos_reg;
    logic            eq_pos_next;
    logic            res_valid_reg;
    res_t            res_reg;
    res_t            res_next;
    logic            res_load;

    cmp_ctl_t        cmp;
    wr_ctl_t         wr;
    logic            flags [DEPTH];
    logic            eqs   [DEPTH];
    entry_t          cells [DEPTH];
    logic [IW-1:0]   pos_enc;
    logic            any_flag;
    logic            eq_enc;

    // The slot chain: every inner slot sees its left and right neighbors; the end slots see themselves instead.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic   lf;
        entry_t ld;
        entry_t rd;
        if (g == 0)
        begin : g_first
            assign lf = 1'b0;
            assign ld = cells[g];
        end
        else
        begin : g_mid
            assign lf = flags[g-1];
            assign ld = cells[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_last
            assign rd = cells[g];
        end
        else
        begin : g_inner
            assign rd = cells[g+1];
        end
        stst_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmp        (cmp),
            .count      (count_reg),
            .index      (op_reg.entry_index),
            .wr         (wr),
            .left_flag  (lf),
            .left_data  (ld),
            .right_data (rd),
            .flag       (flags[g]),
            .eq         (eqs[g]),
            .data       (cells[g])
        );
    end

    // The flags form a thermometer; its first set slot is the insert point, or the indexed slot.
    always_comb
    begin
        pos_enc  = '0;
        any_flag = 1'b0;
        eq_enc   = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (flags[i] && (i == 0 || !flags[(i == 0) ? 0 : i - 1]))
            begin
                pos_enc = pos_enc | IW'(i);
                eq_enc  = eq_enc | eqs[i];
            end
            any_flag = any_flag | flags[i];
        end
    end

    assign pos_next    = any_flag ? CW'(pos_enc) : CW'(DEPTH);
    assign eq_pos_next = any_flag && eq_enc;

    assign cmp.load     = (state_reg == S_CMP);
    assign cmp.by_index = (op_reg.func != FN_INSERT) && (op_reg.func != FN_LOCATE);
    assign cmp.query    = op_reg.sample_time;

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_load  = (state_reg == S_RD) && (!res_valid_reg || !res_stall);

    // Result build and table update, done in the apply cycle.
    always_comb
    begin
        logic          time_ok;
        logic          replace;
        logic          show;
        logic          fresh_sample;
        logic [IW-1:0] lo;
        logic [IW-1:0] hi;

        time_ok      = op_reg.sample_time[62:52] != 11'h7FF;
        replace      = (pos_reg < count_reg) && eq_pos_reg;
        show         = 1'b0;
        fresh_sample = 1'b0;
        lo           = '0;
        hi           = '0;
        count_next   = count_reg;
        kind_next    = kind_reg;
        res_next     = '0;
        wr.op        = WR_NONE;
        wr.fresh.tbits   = op_reg.sample_time;
        wr.fresh.payload = op_reg.value_payload;
        wr.fresh.blocked = op_reg.value_kind == KIND_BLOCKED;

        case (op_reg.func)
            FN_INSERT:
            begin
                if (!time_ok)
                    res_next.status = ST_BAD_TIME;
                else if (op_reg.value_kind == KIND_NONE)
                    res_next.status = ST_BAD_KIND;
                else if (kind_reg != KIND_NONE && op_reg.value_kind != KIND_BLOCKED
                         && op_reg.value_kind != kind_reg)
                    res_next.status = ST_MISMATCH;
                else if (!replace && count_reg == CW'(DEPTH))
                    res_next.status = ST_FULL;
                else
                begin
                    show = 1'b1;
                    lo   = IW'(pos_reg);
                    hi   = IW'(pos_reg);
                    res_next.exact_hit = replace;
                    fresh_sample = !replace;
                    if (replace)
                        wr.op = WR_REPLACE;
                    else
                    begin
                        wr.op      = WR_INSERT;
                        count_next = count_reg + CW'(1);
                    end
                    if (kind_reg == KIND_NONE && op_reg.value_kind != KIND_BLOCKED)
                        kind_next = op_reg.value_kind;
                end
            end
            FN_REMOVE:
            begin
                if (CW'(32'(op_reg.entry_index)) >= count_reg
                    || 32'(op_reg.entry_index) >= 32'(DEPTH))
                    res_next.status = ST_RANGE;
                else
                begin
                    wr.op      = WR_REMOVE;
                    count_next = count_reg - CW'(1);
                    if (count_reg == CW'(1))
                        kind_next = KIND_NONE;
                end
            end
            FN_LOCATE:
            begin
                if (count_reg == '0)
                    res_next.status = ST_EMPTY;
                else
                begin
                    show = 1'b1;
                    if (pos_reg >= count_reg)
                    begin
                        lo = IW'(count_reg - CW'(1));
                        hi = lo;
                    end
                    else if (eq_pos_reg)
                    begin
                        lo = IW'(pos_reg);
                        hi = lo;
                        res_next.exact_hit = 1'b1;
                    end
                    else if (pos_reg == '0)
                    begin
                        lo = '0;
                        hi = '0;
                    end
                    else
                    begin
                        lo = IW'(pos_reg - CW'(1));
                        hi = IW'(pos_reg);
                    end
                end
            end
            FN_READ:
            begin
                if (CW'(32'(op_reg.entry_index)) >= count_reg
                    || 32'(op_reg.entry_index) >= 32'(DEPTH))
                    res_next.status = ST_RANGE;
                else
                begin
                    show = 1'b1;
                    lo   = IW'(op_reg.entry_index);
                    hi   = lo;
                end
            end
            FN_CLEAR:
            begin
                count_next = '0;
                kind_next  = KIND_NONE;
            end
            default:
            begin
                res_next.status = ST_OK;
            end
        endcase

        if (show)
        begin
            res_next.lo_index = 6'(lo);
            res_next.hi_index = 6'(hi);
            if (fresh_sample)
            begin
                res_next.lo_time   = op_reg.sample_time;
                res_next.hi_time   = op_reg.sample_time;
            end
            else
            begin
                res_next.lo_time   = cells[lo].tbits;
                res_next.hi_time   = cells[hi].tbits;
            end
            if (op_reg.func == FN_INSERT)
            begin
                res_next.held_value   = wr.fresh.payload;
                res_next.held_blocked = wr.fresh.blocked;
            end
            else
            begin
                res_next.held_value   = cells[lo].payload;
                res_next.held_blocked = cells[lo].blocked;
            end
        end
        res_next.table_kind   = kind_next;
        res_next.sample_count = 7'(count_next);

        if (!res_load)
        begin
            wr.op      = WR_NONE;
            count_next = count_reg;
            kind_next  = kind_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_SEL;
            end
            S_SEL:
            begin
                state_next = S_RD;
            end
            S_RD:
            begin
                if (res_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            kind_reg      <= KIND_NONE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            kind_reg  <= kind_next;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
            op_reg <= cmd;
        if (state_reg == S_SEL)
        begin
            pos_reg    <= pos_next;
            eq_pos_reg <= eq_pos_next;
        end
        if (res_load)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* hdl/stst_cell.sv */
// One table slot: holds a sample, compares it against the query and shifts with its neighbors.
module stst_cell import stst_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmp_ctl_t                   cmp,
    input  logic [$clog2(DEPTH+1)-1:0] count,
    input  logic [5:0]                 index,
    input  wr_ctl_t                    wr,
    input  logic                       left_flag,
    input  entry_t                     left_data,
    input  entry_t                     right_data,
    output logic                       flag,
    output logic                       eq,
    output entry_t                     data
);

    logic   flag_reg;
    logic   eq_reg;
    logic   live;
    entry_t data_reg;
    entry_t data_next;

    assign live = 32'(IDX) < 32'(count);

    // The flag marks slots at or after the insert point, or at or after the index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
            eq_reg   <= 1'b0;
        end
        else if (cmp.load)
        begin
            if (cmp.by_index)
                flag_reg <= 32'(IDX) >= 32'(index);
            else
                flag_reg <= !live || !f_lt(data_reg.tbits, cmp.query);
            eq_reg <= live && f_eq(data_reg.tbits, cmp.query);
        end
    end

    always_comb
    begin
        data_next = data_reg;
        case (wr.op)
            WR_INSERT:
            begin
                if (left_flag)
                    data_next = left_data;
                else if (flag_reg)
                    data_next = wr.fresh;
            end
            WR_REPLACE:
            begin
                if (flag_reg && !left_flag)
                begin
                    data_next.payload = wr.fresh.payload;
                    data_next.blocked = wr.fresh.blocked;
                end
            end
            WR_REMOVE:
            begin
                if (flag_reg)
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign flag = flag_reg;
    assign eq   = eq_reg;
    assign data = data_reg;

endmodule
